// File: rtl/integer_sqrt_lut_newton_defines.svh
// Assertion macros for the integer square root block.
`ifndef INTEGER_SQRT_LUT_NEWTON_DEFINES_SVH
`define INTEGER_SQRT_LUT_NEWTON_DEFINES_SVH
`ifndef SYNTH
`define ISQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ISQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ISQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ISQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/isq_pkg.sv
// ----------------------------------------------------------------------------
// isq_pkg
// Shared widths, seed ROM and divider cell payload for the square root.
// ----------------------------------------------------------------------------
package isq_pkg;
	localparam int RadW  = 64;
	localparam int RootW = 32;
	localparam int DivW  = 32;

	// Data handed from one divider cell to the next.
	typedef struct packed {
		logic             vld;
		logic             step2;   // 0: first Newton step, 1: second
		logic             bypass;  // small radicand, result already known
		logic [RadW-1:0]  x;       // radicand
		logic [DivW-1:0]  d;       // divisor (current estimate)
		logic [RadW-1:0]  rem;     // partial remainder
		logic [RadW-1:0]  quo;     // quotient bits built so far
	} cell_t;

	function automatic logic [4:0] rom(input logic [7:0] i);
		logic [4:0] r;
		begin
			r = 5'd1;
			if (i >= 8'd3)   r = 5'd2;
			if (i >= 8'd7)   r = 5'd3;
			if (i >= 8'd13)  r = 5'd4;
			if (i >= 8'd21)  r = 5'd5;
			if (i >= 8'd31)  r = 5'd6;
			if (i >= 8'd43)  r = 5'd7;
			if (i >= 8'd57)  r = 5'd8;
			if (i >= 8'd73)  r = 5'd9;
			if (i >= 8'd91)  r = 5'd10;
			if (i >= 8'd111) r = 5'd11;
			if (i >= 8'd133) r = 5'd12;
			if (i >= 8'd157) r = 5'd13;
			if (i >= 8'd183) r = 5'd14;
			if (i >= 8'd211) r = 5'd15;
			if (i >= 8'd241) r = 5'd16;
			return r;
		end
	endfunction
endpackage

// File: rtl/isq_div_cell.sv
// ----------------------------------------------------------------------------
// isq_div_cell
// One restoring-division bit: shifts in one radicand bit, trial-subtracts.
// ----------------------------------------------------------------------------
module isq_div_cell #(
	parameter int Bit = 63
) (
	input  logic           clk,
	input  logic           arst_n,
	input  isq_pkg::cell_t din,
	output isq_pkg::cell_t dout_q
);
	logic [isq_pkg::RadW:0] sh;
	logic [isq_pkg::RadW:0] diff;

	always_comb begin
		sh   = {din.rem, din.x[Bit]};
		diff = sh - {{(isq_pkg::RadW + 1 - isq_pkg::DivW){1'b0}}, din.d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_q <= '0;
		end else begin
			dout_q.vld    <= din.vld;
			dout_q.step2  <= din.step2;
			dout_q.bypass <= din.bypass;
			dout_q.x      <= din.x;
			dout_q.d      <= din.d;
			if (!diff[isq_pkg::RadW]) begin
				dout_q.rem <= diff[isq_pkg::RadW-1:0];
				dout_q.quo <= {din.quo[isq_pkg::RadW-2:0], 1'b1};
			end else begin
				dout_q.rem <= sh[isq_pkg::RadW-1:0];
				dout_q.quo <= {din.quo[isq_pkg::RadW-2:0], 1'b0};
			end
		end
	end
endmodule

// File: rtl/isq_div_chain.sv
// ----------------------------------------------------------------------------
// isq_div_chain
// Row of 64 division cells giving x / d; a zero divisor yields all ones.
// ----------------------------------------------------------------------------
module isq_div_chain (
	input  logic           clk,
	input  logic           arst_n,
	input  isq_pkg::cell_t din,
	output isq_pkg::cell_t dout
);
	isq_pkg::cell_t link [isq_pkg::RadW+1];

	always_comb begin
		link[0]     = din;
		link[0].rem = '0;
		link[0].quo = '0;
	end

	for (genvar g = 0; g < isq_pkg::RadW; g++) begin : g_cell
		isq_div_cell #(.Bit(isq_pkg::RadW - 1 - g)) u_cell (
			.clk(clk), .arst_n(arst_n), .din(link[g]), .dout_q(link[g+1])
		);
	end

	// restoring division with d == 0 already gives an all-ones quotient
	assign dout = link[isq_pkg::RadW];
endmodule

// File: rtl/integer_sqrt_lut_newton.sv
// ----------------------------------------------------------------------------
// integer_sqrt_lut_newton
// Rounded 64-bit integer square root: ROM seed and two Newton steps.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with radicand; an item is taken whenever start is high
//   (busy is tied low, so a new item can enter every cycle).
//   root appears with done high for exactly one cycle; the receiver must
//   take it then, it cannot stall the block.
// Pipeline: seed register, first division chain, first update register,
//   second division chain, output register.
// Throughput: one item per cycle. Each quotient bit is a cell of the
//   chain, so 128 cells of restoring division set the latency.
// Results leave in item order. Reset clears all valid flags; items in
//   flight are dropped.
// Radicands below 256 take the ROM entry directly; they still ride the
//   pipeline so order is kept.
// ----------------------------------------------------------------------------
`include "integer_sqrt_lut_newton_defines.svh"

module integer_sqrt_lut_newton (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	isq_pkg::cell_t seed_s1, div1_out, upd_s2, div2_out;
	logic [4:0]  entry;
	logic [31:0] seed;
	logic        byte_only;
	logic [64:0] sum1;
	logic [64:0] sum2;

	assign busy = 1'b0;

	// priority seed pick
	always_comb begin
		byte_only = 1'b0;
		entry = isq_pkg::rom(radicand[7:0]);
		seed  = {27'd0, entry};
		if (radicand[63:56] != 8'd0) begin
			entry = isq_pkg::rom(radicand[63:56]);
			seed  = ({27'd0, entry} << 28) - 32'd1;
		end else if (radicand[55:48] != 8'd0) begin
			entry = isq_pkg::rom(radicand[55:48]);
			seed  = {27'd0, entry} << 24;
		end else if (radicand[47:40] != 8'd0) begin
			entry = isq_pkg::rom(radicand[47:40]);
			seed  = {27'd0, entry} << 20;
		end else if (radicand[39:32] != 8'd0) begin
			entry = isq_pkg::rom(radicand[39:32]);
			seed  = {27'd0, entry} << 16;
		end else if (radicand[31:24] != 8'd0) begin
			entry = isq_pkg::rom(radicand[31:24]);
			seed  = {27'd0, entry} << 12;
		end else if (radicand[23:16] != 8'd0) begin
			entry = isq_pkg::rom(radicand[23:16]);
			seed  = {27'd0, entry} << 8;
		end else if (radicand[15:8] != 8'd0) begin
			entry = isq_pkg::rom(radicand[15:8]);
			seed  = {27'd0, entry} << 4;
		end else begin
			byte_only = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_s1 <= '0;
		end else begin
			seed_s1.vld    <= start;
			seed_s1.step2  <= 1'b0;
			seed_s1.bypass <= byte_only;
			seed_s1.x      <= radicand;
			seed_s1.d      <= seed;
			seed_s1.rem    <= '0;
			seed_s1.quo    <= '0;
		end
	end

	isq_div_chain u_div1 (.clk(clk), .arst_n(arst_n), .din(seed_s1), .dout(div1_out));

	// first update: a1 = (a0 + x/a0) >> 1, sum kept to 65 bits
	assign sum1 = {33'd0, div1_out.d} + {1'b0, div1_out.quo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s2 <= '0;
		end else begin
			upd_s2.vld    <= div1_out.vld;
			upd_s2.step2  <= 1'b1;
			upd_s2.bypass <= div1_out.bypass;
			upd_s2.x      <= div1_out.x;
			upd_s2.d      <= div1_out.bypass ? div1_out.d : sum1[32:1];
			upd_s2.rem    <= '0;
			upd_s2.quo    <= '0;
		end
	end

	isq_div_chain u_div2 (.clk(clk), .arst_n(arst_n), .din(upd_s2), .dout(div2_out));

	// second update rounds up; sum taken modulo 2^64
	assign sum2 = {1'b0, {32'd0, div2_out.d} + div2_out.quo + 64'd1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div2_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		root <= div2_out.bypass ? div2_out.d : sum2[32:1];
	end

	`ISQ_ASSERT_IMPL(a_never_busy, clk, arst_n, 1'b1, !busy)
	`ISQ_ASSERT_NEXT(a_seed_vld, clk, arst_n, start, seed_s1.vld)
	`ISQ_ASSERT_IMPL(a_seed_nz, clk, arst_n, seed_s1.vld, seed_s1.d != 32'd0)
	`ISQ_ASSERT_NEXT(a_done_follows, clk, arst_n, div2_out.vld, done)
	`ISQ_ASSERT_IMPL(a_step_tag, clk, arst_n, upd_s2.vld, upd_s2.step2)
endmodule

// File: dv/integer_sqrt_lut_newton_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_sqrt_lut_newton_tb
// Self-checking bench for the rounded 64-bit integer square root.
// Sends radicands in random bursts. Each one is predicted with a behavioral
// ROM seed and two Newton steps. Roots come back in order and are compared
// against a queue of expected values.
// ----------------------------------------------------------------------------
module integer_sqrt_lut_newton_tb;
	localparam int Latency = 131;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] radicand;
	logic        done;
	logic [31:0] root;

	logic [63:0] pending_q[$];   // radicands waiting to be sent
	logic [31:0] root_exp_q[$];  // predicted roots, oldest first
	int          errors = 0;
	int          gap_left = 0;
	int          burst_left = 0;
	bit          hold_off = 0;   // sender pauses until the pipe drains
	bit          resumed = 0;    // pause already taken

	integer_sqrt_lut_newton u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.radicand(radicand), .done(done), .root(root)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Seed table: entry is the rounded root of the byte index, with index 0 giving 1.
	function automatic logic [4:0] seed_entry(input logic [7:0] i);
		int r;
		r = 1;
		while ((r + 1) * r < i) r++;
		return r[4:0];
	endfunction

	// Divider with a zero divisor giving all ones.
	function automatic logic [63:0] quot64(input logic [63:0] n, input logic [31:0] d);
		if (d == 0)
			return '1;
		return n / {32'd0, d};
	endfunction

	function automatic logic [31:0] sqrt_round(input logic [63:0] x);
		logic [31:0] a;
		logic [63:0] sum;
		if (x < 64'd256)
			return {27'd0, seed_entry(x[7:0])};
		if (x[63:56] != 0)
			a = ({27'd0, seed_entry(x[63:56])} << 28) - 32'd1;  // wraps at entry 16
		else if (x[55:48] != 0) a = {27'd0, seed_entry(x[55:48])} << 24;
		else if (x[47:40] != 0) a = {27'd0, seed_entry(x[47:40])} << 20;
		else if (x[39:32] != 0) a = {27'd0, seed_entry(x[39:32])} << 16;
		else if (x[31:24] != 0) a = {27'd0, seed_entry(x[31:24])} << 12;
		else if (x[23:16] != 0) a = {27'd0, seed_entry(x[23:16])} << 8;
		else                    a = {27'd0, seed_entry(x[15:8])} << 4;
		sum = {32'd0, a} + quot64(x, a);
		a = sum[32:1];
		sum = {32'd0, a} + quot64(x, a) + 64'd1;  // mod 2^64, may wrap to zero
		return sum[32:1];
	endfunction

	// Driver: bursts and gaps; start held across back-to-back items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			radicand <= '0;
		end else begin
			if (start && !busy) begin
				root_exp_q.push_back(sqrt_round(radicand));
			end
			if (start && busy) begin
				// item still pending, keep it
			end else if (hold_off && !resumed && (root_exp_q.size() != 0 || start)) begin
				start <= 1'b0;
			end else if (pending_q.size() == 0) begin
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else begin
				if (hold_off) resumed <= 1'b1;
				radicand <= pending_q.pop_front();
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Monitor: done is a one-cycle strobe.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (root_exp_q.size() == 0) begin
				$display("%0t: unexpected root %h", $time, root);
				errors++;
			end else begin
				logic [31:0] exp_root;
				exp_root = root_exp_q.pop_front();
				if (root !== exp_root) begin
					$display("%0t: root mismatch exp %h got %h", $time, exp_root, root);
					errors++;
				end
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [63:0] v;
		int          sh;
		arst_n = 1'b0;
		// directed: small values, range edges, top wrap, near 2^64
		pending_q.push_back(64'd0);
		pending_q.push_back(64'd1);
		pending_q.push_back(64'd255);
		pending_q.push_back(64'd256);
		pending_q.push_back(64'hFFFF);
		pending_q.push_back(64'h1_0000);
		pending_q.push_back(64'hFF_FFFF);
		pending_q.push_back(64'h100_0000);
		pending_q.push_back(64'hFFFF_FFFF);
		pending_q.push_back(64'h1_0000_0000);
		pending_q.push_back(64'h0100_0000_0000_0000);
		pending_q.push_back(64'h00FF_FFFF_FFFF_FFFF);
		pending_q.push_back(64'hF100_0000_0000_0000);
		pending_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		pending_q.push_back(64'hFFFF_FFFE_0000_0001);
		pending_q.push_back(64'hFFFF_FFFF_0000_0000);
		pending_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
		pending_q.push_back(64'h5555_5555_5555_5555);
		pending_q.push_back(64'h0000_0010_0000_0000);
		pending_q.push_back(64'h0000_1000_0000_0000);
		repeat (1000) begin
			v = rand64();
			case ($urandom_range(0, 3))
				0: v = v >> $urandom_range(0, 63);  // spread over every shift range
				1: begin
					sh = $urandom_range(0, 31);
					v = {32'd0, v[31:0] >> sh};
					v = v * v + $urandom_range(0, 2) - 1;  // near perfect squares
				end
				2: v = ~(v >> $urandom_range(32, 63));  // near 2^64
				default: ;
			endcase
			pending_q.push_back(v);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// pause once, mid-run, until every root is back
		while (pending_q.size() >= 500) @(posedge clk);
		@(posedge clk);
		hold_off <= 1'b1;
		while (pending_q.size() != 0) @(posedge clk);
		@(posedge clk);
		@(posedge clk);
		while (start || root_exp_q.size() != 0) @(posedge clk);
		repeat (Latency + 20) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/isq_pkg.sv
rtl/isq_div_cell.sv
rtl/isq_div_chain.sv
rtl/integer_sqrt_lut_newton.sv
dv/integer_sqrt_lut_newton_tb.sv
